>>> rtl/fconv_pkg.sv
// Shared types and constants of the full linear convolution block.
package fconv_pkg;

	localparam int MAX_TAPS_DEF = 16;
	localparam int VAL_W        = 16;
	localparam int PROD_W       = 32;
	localparam int SUM_W        = 40;

	localparam logic MODE_KERNEL = 1'b0;
	localparam logic MODE_DATA   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// control of the partial-sum ring besides its read and write ports
	typedef struct packed {
		logic clr_all;
		logic take;
	} ring_ctl_t;

endpackage

>>> rtl/fconv_tap_mem.sv
// Kernel tap memory: one write port, one registered read port.
module fconv_tap_mem #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF,
	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [IDX_W-1:0]                    wr_addr,
	input  logic signed [fconv_pkg::VAL_W-1:0]  wr_data,
	input  logic                                rd_en,
	input  logic [IDX_W-1:0]                    rd_addr,
	output logic signed [fconv_pkg::VAL_W-1:0]  rd_data
);
	import fconv_pkg::*;

	logic signed [VAL_W-1:0] mem [MAX_TAPS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/fconv_sum_ring.sv
// Partial-sum ring memory with per-entry valid bits; an invalid entry reads as zero.
module fconv_sum_ring #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF,
	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fconv_pkg::ring_ctl_t                ctl,
	input  logic [IDX_W-1:0]                    take_addr,
	input  logic                                wr_en,
	input  logic [IDX_W-1:0]                    wr_addr,
	input  logic signed [fconv_pkg::SUM_W-1:0]  wr_data,
	input  logic                                rd_en,
	input  logic [IDX_W-1:0]                    rd_addr,
	output logic signed [fconv_pkg::SUM_W-1:0]  rd_data
);
	import fconv_pkg::*;

	logic signed [SUM_W-1:0] mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]     vld_q;
	logic signed [SUM_W-1:0] mem_rd_q;
	logic                    vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
			vld_rd_q <= vld_q[rd_addr];
		end
	end

	// clear all on a ring reset, drop one entry when the oldest sum is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.clr_all) begin
			vld_q <= '0;
		end else begin
			if (ctl.take) begin
				vld_q[take_addr] <= 1'b0;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule

>>> rtl/fconv_mac.sv
// Shared multiply-accumulate pipeline: product stage, then add and write back.
module fconv_mac #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF,
	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                issue,
	input  logic [IDX_W-1:0]                    idx,
	input  logic signed [fconv_pkg::VAL_W-1:0]  sample,
	input  logic signed [fconv_pkg::VAL_W-1:0]  tap,
	input  logic signed [fconv_pkg::SUM_W-1:0]  psum,
	output logic                                wr_en,
	output logic [IDX_W-1:0]                    wr_addr,
	output logic signed [fconv_pkg::SUM_W-1:0]  wr_data,
	output logic                                busy
);
	import fconv_pkg::*;

	logic                     v_s1, v_s2;
	logic [IDX_W-1:0]         idx_s1, idx_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  psum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// s1: tap and partial sum arrive from the memories
	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		idx_s2  <= idx_s1;
		prod_s2 <= PROD_W'(sample) * PROD_W'(tap);
		psum_s2 <= psum;
	end

	assign wr_en   = v_s2;
	assign wr_addr = idx_s2;
	assign wr_data = psum_s2 + {{(SUM_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign busy    = v_s1 | v_s2;

endmodule

>>> rtl/full_linear_convolution.sv
// Top level of the streaming full linear convolution block.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  item    | in        | item_valid / item_ready  | mode, value, last
//  res     | out       | res_valid  / res_ready   | result, end_of_output
//
// A kernel word (mode 0) is stored in the idle state. A data word runs through
// the shared multiply-accumulate loop (n = stored taps, one tap per cycle through one
// 16x16 multiplier and one 40-bit adder; skipped when no tap is stored), then through
// a ring read state and a load state per result word at the single read port of the
// partial-sum ring; a last data word emits max(n,1) results, others emit one.
// Reset clears all control state and the ring valid bits at once; no sweep.
// A result word waits in the output register while the next item is accepted;
// the sequencer holds before the next ring read until that register is empty.
module full_linear_convolution #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                mode,
	input  logic signed [fconv_pkg::VAL_W-1:0]  value,
	input  logic                                last,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [fconv_pkg::SUM_W-1:0]  result,
	output logic                                end_of_output
);
	import fconv_pkg::*;

	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int LEN_W = $clog2(MAX_TAPS + 1);

	state_t state_q, state_nx;

	logic [LEN_W-1:0]        len_q;
	logic                    complete_q;
	logic [IDX_W-1:0]        head_q;
	logic [LEN_W-1:0]        j_q;
	logic [IDX_W-1:0]        idx_q;
	logic [LEN_W-1:0]        emit_q;
	logic signed [VAL_W-1:0] sample_q;
	logic                    last_q;

	logic                    out_valid_q;
	logic signed [SUM_W-1:0] result_q;
	logic                    end_q;

	logic                    accept;
	logic                    kern_wr;
	logic [LEN_W-1:0]        kern_base;
	logic [LEN_W-1:0]        n_eff;
	logic [LEN_W-1:0]        emit_nx;
	logic                    emit_done;
	logic                    mac_issue;
	logic                    ring_rd;
	logic [IDX_W-1:0]        ring_rd_addr;
	ring_ctl_t               ring_ctl;

	logic signed [VAL_W-1:0] tap_rd;
	logic signed [SUM_W-1:0] ring_data;
	logic                    mac_wr;
	logic [IDX_W-1:0]        mac_wr_addr;
	logic signed [SUM_W-1:0] mac_wr_data;
	logic                    mac_busy;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	// a kernel word after a finished kernel starts over at tap zero
	assign kern_base = complete_q ? '0 : len_q;
	assign kern_wr   = accept && (mode == MODE_KERNEL) && (kern_base < LEN_W'(MAX_TAPS));

	// an empty kernel acts as a single zero tap
	assign n_eff     = (len_q == '0) ? LEN_W'(1) : len_q;
	assign emit_nx   = emit_q + LEN_W'(1);
	assign emit_done = !last_q || (emit_nx == n_eff);

	assign mac_issue    = (state_q == ST_MAC);
	assign ring_rd      = mac_issue || ((state_q == ST_EMIT_RD) && !out_valid_q);
	assign ring_rd_addr = mac_issue ? idx_q : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx         = state_q;
		ring_ctl.clr_all = 1'b0;
		ring_ctl.take    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_KERNEL) begin
						ring_ctl.clr_all = complete_q;
					end else begin
						state_nx = (len_q == '0) ? ST_DRAIN : ST_MAC;
					end
				end
			end
			ST_MAC: begin
				if (LEN_W'(j_q + LEN_W'(1)) == len_q) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// hold until every product is written back
				if (!mac_busy) begin
					state_nx = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				if (!out_valid_q) begin
					state_nx = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				ring_ctl.take = 1'b1;
				if (emit_done) begin
					ring_ctl.clr_all = last_q;
					state_nx         = ST_IDLE;
				end else begin
					state_nx = ST_EMIT_RD;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer counters and kernel bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			complete_q <= 1'b1;
			head_q     <= '0;
			j_q        <= '0;
			idx_q      <= '0;
			emit_q     <= '0;
			last_q     <= 1'b0;
		end else begin
			if (accept && (mode == MODE_KERNEL)) begin
				if (kern_wr) begin
					len_q <= kern_base + LEN_W'(1);
				end else begin
					len_q <= kern_base;
				end
				complete_q <= last;
				if (complete_q) begin
					head_q <= '0;
				end
			end
			if (accept && (mode == MODE_DATA)) begin
				last_q <= last;
				j_q    <= '0;
				idx_q  <= head_q;
				emit_q <= '0;
			end
			if (mac_issue) begin
				j_q   <= j_q + LEN_W'(1);
				idx_q <= (idx_q == IDX_W'(MAX_TAPS - 1)) ? '0 : idx_q + IDX_W'(1);
			end
			if (state_q == ST_EMIT_LD) begin
				emit_q <= emit_nx;
				// advance to the next oldest sum, or rewind after the last one
				if (emit_done && last_q) begin
					head_q <= '0;
				end else begin
					head_q <= (head_q == IDX_W'(MAX_TAPS - 1)) ? '0 : head_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_DATA)) begin
			sample_q <= value;
		end
	end

	// output register: a finished word waits here while the next item goes on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_LD) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			result_q <= ring_data;
			end_q    <= last_q && (emit_nx == n_eff);
		end
	end

	assign res_valid     = out_valid_q;
	assign result        = result_q;
	assign end_of_output = end_q;

	fconv_tap_mem #(
		.MAX_TAPS (MAX_TAPS)
	) u_taps (
		.clk     (clk),
		.wr_en   (kern_wr),
		.wr_addr (kern_base[IDX_W-1:0]),
		.wr_data (value),
		.rd_en   (mac_issue),
		.rd_addr (j_q[IDX_W-1:0]),
		.rd_data (tap_rd)
	);

	fconv_sum_ring #(
		.MAX_TAPS (MAX_TAPS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.take_addr (head_q),
		.wr_en     (mac_wr),
		.wr_addr   (mac_wr_addr),
		.wr_data   (mac_wr_data),
		.rd_en     (ring_rd),
		.rd_addr   (ring_rd_addr),
		.rd_data   (ring_data)
	);

	fconv_mac #(
		.MAX_TAPS (MAX_TAPS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (mac_issue),
		.idx     (idx_q),
		.sample  (sample_q),
		.tap     (tap_rd),
		.psum    (ring_data),
		.wr_en   (mac_wr),
		.wr_addr (mac_wr_addr),
		.wr_data (mac_wr_data),
		.busy    (mac_busy)
	);

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !mac_busy)
		else $error("item accepted while products still in flight");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_TAPS))
		else $error("kernel length beyond tap capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD) |-> !out_valid_q)
		else $error("output register overwritten");

	a_mac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (j_q < len_q))
		else $error("tap counter ran past kernel length");

endmodule
